FILE: hw/rtl/svpwm_bc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Space-vector PWM package
// Shared types and fixed-point constants of the bus-compensated SVPWM block.
// ----------------------------------------------------------------------------
package svpwm_bc_pkg;

  // Q30 fixed-point one and the scaled constants.
  localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
  localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;
  localparam logic [30:0] PI3_Q30   = 31'd1124419809;

  // Reciprocals for exact floor division of 31-bit values by small constants.
  // Each is rounded up so that the product never falls below the true quotient.
  localparam logic [31:0] RECIP_42 = 32'd3272356036;
  localparam int          SHIFT_42 = 37;
  localparam logic [31:0] RECIP_20 = 32'd3435973837;
  localparam int          SHIFT_20 = 36;
  localparam logic [31:0] RECIP_6  = 32'd2863311531;
  localparam int          SHIFT_6  = 34;

  // Pipeline stage map.
  localparam int ST_SETUP     = 2;
  localparam int ST_DIV_FIRST = 3;
  localparam int ST_DIV_LAST  = 33;
  localparam int ST_X2        = 3;
  localparam int ST_D42       = 4;
  localparam int ST_P1        = 5;
  localparam int ST_D20       = 6;
  localparam int ST_P2        = 7;
  localparam int ST_D6        = 8;
  localparam int ST_SINE      = 9;
  localparam int ST_ACTIVE    = 34;
  localparam int ST_HIGH      = 35;
  localparam int ST_COMPARE   = 36;
  localparam int NUM_STAGES   = 36;

  // Reset value of the period register.
  localparam logic [15:0] PERIOD_RESET = 16'd7500;

  // Everything one item carries down the pipeline.
  typedef struct packed {
    logic [2:0]        sec;
    logic              clamp;
    logic [15:0]       bus;
    logic [46:0]       num;
    logic [16:0]       rem;
    logic [30:0]       q;
    logic [1:0][16:0]  f;
    logic [1:0][30:0]  x;
    logic [1:0][30:0]  x2;
    logic [1:0][30:0]  d;
    logic [1:0][30:0]  p;
    logic [1:0][30:0]  act;
    logic [2:0][30:0]  h;
    logic [2:0][15:0]  cmp;
  } item_t;

endpackage

FILE: hw/rtl/svpwm_bus_compensated_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus-compensated space-vector PWM
// Turns a voltage vector and the DC bus voltage into three compare values.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one beat per update: magnitude, angle and bus
//   voltage. The master stream returns one beat per input: three phase
//   compare values in tdata, the sector (1 to 6) and the clamp flag in tuser.
//   The period register is written through the cfg channel, which is always
//   ready; write it only while no beat is in flight.
// Throughput:
//   The pipeline takes one beat every cycle while the output is not stalled;
//   its length is set by the restoring divider for the modulation index,
//   which resolves one quotient bit per stage.
// Reset:
//   rst clears all stage valid bits and loads the period with 7500.
// Stalls:
//   Each stage holds its beat while the next one is full and stalled, so
//   empty stages still fill and the input keeps accepting beats until the
//   whole pipeline is full behind a stalled output.
// ----------------------------------------------------------------------------
module svpwm_bus_compensated_top #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  // Slave data, low bit first: magnitude[15:0], angle, bus_voltage[15:0].
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [((32 + ANGLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // Master data, low bit first: compare_a, compare_b, compare_c.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,
  // Master user, low bit first: sector[2:0], index_clamped.
  output logic [3:0]          m_axis_tuser,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  localparam int NS     = svpwm_bc_pkg::NUM_STAGES;
  localparam int SCW    = ANGLE_BITS + 3;
  localparam int SH_R   = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int SH_L   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  // One pipeline step; k selects the work of the stage being loaded.
  function automatic svpwm_bc_pkg::item_t step(input int k,
                                              input svpwm_bc_pkg::item_t s,
                                              input logic [15:0] per);
    svpwm_bc_pkg::item_t o;
    logic [63:0]       prod;
    logic [16:0]       r;
    logic [30:0]       m;
    logic [32:0]       sum;
    logic [32:0]       zero;
    logic [32:0]       half;
    logic [2:0][32:0]  hh;
    logic [32:0]       one33;
    int                i;
    o     = s;
    one33 = 33'(svpwm_bc_pkg::Q30_ONE);
    // Clamp decision, divider setup and sine argument.
    if (k == svpwm_bc_pkg::ST_SETUP) begin
      o.clamp = (s.bus == 16'd0) || (64'(s.num) > (64'(s.bus) << 30));
      o.rem   = {1'b0, s.num[46:31]};
      for (int j = 0; j < 2; j++) begin
        prod   = 64'(s.f[j]) * 64'(svpwm_bc_pkg::PI3_Q30);
        o.x[j] = 31'(prod >> 16);
      end
    end
    // Restoring division, one quotient bit per stage.
    if (k >= svpwm_bc_pkg::ST_DIV_FIRST && k <= svpwm_bc_pkg::ST_DIV_LAST) begin
      i = svpwm_bc_pkg::ST_DIV_LAST - k;
      r = {s.rem[15:0], s.num[i]};
      if (r >= {1'b0, s.bus}) begin
        o.rem  = r - {1'b0, s.bus};
        o.q[i] = 1'b1;
      end else begin
        o.rem  = r;
        o.q[i] = 1'b0;
      end
    end
    // Sine polynomial, one multiply per stage in each lane.
    for (int j = 0; j < 2; j++) begin
      if (k == svpwm_bc_pkg::ST_X2) begin
        prod    = 64'(s.x[j]) * 64'(s.x[j]);
        o.x2[j] = 31'(prod >> 30);
      end
      if (k == svpwm_bc_pkg::ST_D42) begin
        prod   = 64'(s.x2[j]) * 64'(svpwm_bc_pkg::RECIP_42);
        o.d[j] = 31'(prod >> svpwm_bc_pkg::SHIFT_42);
      end
      if (k == svpwm_bc_pkg::ST_P1 || k == svpwm_bc_pkg::ST_P2) begin
        prod   = 64'(s.x2[j]) * (64'(svpwm_bc_pkg::Q30_ONE) - 64'(s.d[j]));
        o.p[j] = 31'(prod >> 30);
      end
      if (k == svpwm_bc_pkg::ST_D20) begin
        prod   = 64'(s.p[j]) * 64'(svpwm_bc_pkg::RECIP_20);
        o.d[j] = 31'(prod >> svpwm_bc_pkg::SHIFT_20);
      end
      if (k == svpwm_bc_pkg::ST_D6) begin
        prod   = 64'(s.p[j]) * 64'(svpwm_bc_pkg::RECIP_6);
        o.d[j] = 31'(prod >> svpwm_bc_pkg::SHIFT_6);
      end
      if (k == svpwm_bc_pkg::ST_SINE) begin
        prod   = 64'(s.x[j]) * (64'(svpwm_bc_pkg::Q30_ONE) - 64'(s.d[j]));
        o.p[j] = 31'(prod >> 30);
      end
    end
    // Active times from the index and the two sines.
    if (k == svpwm_bc_pkg::ST_ACTIVE) begin
      m = s.clamp ? svpwm_bc_pkg::Q30_ONE : s.q;
      for (int j = 0; j < 2; j++) begin
        prod     = 64'(m) * 64'(s.p[j]);
        o.act[j] = 31'(prod >> 30);
      end
    end
    // Zero time and the sector table of phase high times.
    if (k == svpwm_bc_pkg::ST_HIGH) begin
      sum  = 33'(s.act[0]) + 33'(s.act[1]);
      zero = (sum > one33) ? 33'd0 : one33 - sum;
      half = zero >> 1;
      unique case (s.sec)
        3'd0: begin
          hh[0] = sum + half; hh[1] = 33'(s.act[1]) + half; hh[2] = half;
        end
        3'd1: begin
          hh[0] = 33'(s.act[0]) + half; hh[1] = sum + half; hh[2] = half;
        end
        3'd2: begin
          hh[0] = half; hh[1] = sum + half; hh[2] = 33'(s.act[1]) + half;
        end
        3'd3: begin
          hh[0] = half; hh[1] = 33'(s.act[0]) + half; hh[2] = sum + half;
        end
        3'd4: begin
          hh[0] = 33'(s.act[1]) + half; hh[1] = half; hh[2] = sum + half;
        end
        default: begin
          hh[0] = sum + half; hh[1] = half; hh[2] = 33'(s.act[0]) + half;
        end
      endcase
      for (int n = 0; n < 3; n++) begin
        o.h[n] = (hh[n] > one33) ? svpwm_bc_pkg::Q30_ONE : hh[n][30:0];
      end
    end
    // Compare values against the period.
    if (k == svpwm_bc_pkg::ST_COMPARE) begin
      for (int n = 0; n < 3; n++) begin
        prod     = 64'(per) * (64'(svpwm_bc_pkg::Q30_ONE) - 64'(s.h[n]));
        o.cmp[n] = 16'(prod >> 30);
      end
    end
    return o;
  endfunction

  logic [15:0]         pwm_period;
  logic [NS:1]         vld;
  logic [NS+1:1]       rdy;
  svpwm_bc_pkg::item_t pipe [1:NS];
  svpwm_bc_pkg::item_t nxt  [1:NS];

  logic [15:0]         in_mag;
  logic [ANGLE_BITS-1:0] in_ang;
  logic [15:0]         in_bus;
  logic [SCW-1:0]      scaled;
  logic [ANGLE_BITS-1:0] rel;
  logic [16:0]         f16;
  logic [63:0]         num_prod;

  // Period register; the channel always takes a write.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= svpwm_bc_pkg::PERIOD_RESET;
    end else if (cfg_valid) begin
      pwm_period <= cfg_data;
    end
  end

  // Unpack the input beat.
  assign in_mag = s_axis_tdata[15:0];
  assign in_ang = s_axis_tdata[16 +: ANGLE_BITS];
  assign in_bus = s_axis_tdata[16 + ANGLE_BITS +: 16];

  // First stage: sector, relative angle and the index numerator.
  always_comb begin
    scaled   = SCW'({in_ang, 2'b00}) + SCW'({in_ang, 1'b0});
    rel      = scaled[ANGLE_BITS-1:0];
    f16      = 17'(rel >> SH_R) << SH_L;
    num_prod = 64'(in_mag) * 64'(svpwm_bc_pkg::SQRT3_Q30);
    nxt[1]      = '0;
    nxt[1].sec  = scaled[SCW-1:ANGLE_BITS];
    nxt[1].bus  = in_bus;
    nxt[1].num  = 47'(num_prod);
    nxt[1].f[0] = 17'h1_0000 - f16;
    nxt[1].f[1] = f16;
  end

  // Remaining stages.
  for (genvar k = 2; k <= NS; k++) begin : g_stage
    always_comb begin
      nxt[k] = step(k, pipe[k-1], pwm_period);
    end
  end

  // A stage loads when it is empty or its beat moves on.
  assign rdy[NS+1] = m_axis_tready;
  for (genvar k = 1; k <= NS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign s_axis_tready = rdy[1];

  // Stage registers with their valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
    for (int k = 1; k <= NS; k++) begin
      if (rdy[k]) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  // Output beat.
  assign m_axis_tvalid = vld[NS];
  assign m_axis_tdata  = {pipe[NS].cmp[2], pipe[NS].cmp[1], pipe[NS].cmp[0]};
  assign m_axis_tuser  = {pipe[NS].clamp, 3'(pipe[NS].sec + 3'd1)};

endmodule

FILE: hw/rtl/svpwm_bc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SVPWM port checker
// Watches the stream ports of the SVPWM top level over time.
// ----------------------------------------------------------------------------
module svpwm_bc_chk (
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [47:0]         m_axis_tdata,
  input logic [3:0]          m_axis_tuser
);

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // An empty output stage never blocks the input.
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // A stalled beat stays valid.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped under stall");

  // A stalled beat keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output payload changed under stall");

  // The sector is always one to six.
  a_sector: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[2:0] != 3'd0) && (m_axis_tuser[2:0] != 3'd7))
    else $error("sector out of range");

endmodule

bind svpwm_bus_compensated_top svpwm_bc_chk u_chk (.*);
